### design/svpwm_pkg.sv
// shared constants and helpers for the svpwm duty pipeline
package svpwm_pkg;

  localparam logic [30:0] SinA = 31'd1686629713;
  localparam logic [30:0] SinB = 31'd688904866;
  localparam logic [30:0] SinC = 31'd76016977;
  localparam logic [31:0] Q30One = 32'sd1073741824;
  localparam logic [31:0] Q30Half = 32'sd536870912;
  localparam logic [31:0] Q30HalfSqrt3 = 32'sd929887697;

  // sector lookup from the above, steep and right tests
  function automatic logic [2:0] sector_of_code(input logic [2:0] code);
    logic [2:0] n;
    unique case (code)
      3'd0: n = 3'd4;
      3'd1: n = 3'd6;
      3'd2: n = 3'd5;
      3'd3: n = 3'd5;
      3'd4: n = 3'd3;
      3'd5: n = 3'd1;
      3'd6: n = 3'd2;
      default: n = 3'd2;
    endcase
    return n;
  endfunction

  // switching pattern of sector vector k (1..6), bits u v w
  function automatic logic [2:0] switch_pattern(input logic [2:0] k);
    logic [2:0] p;
    unique case (k)
      3'd1: p = 3'b100;
      3'd2: p = 3'b110;
      3'd3: p = 3'b010;
      3'd4: p = 3'b011;
      3'd5: p = 3'b001;
      default: p = 3'b101;
    endcase
    return p;
  endfunction

  // sin of k*60 degrees, Q30
  function automatic logic signed [31:0] sin_sixty(input logic [2:0] k);
    logic signed [31:0] v;
    case (k)
      3'd1, 3'd2: v = Q30HalfSqrt3;
      3'd4, 3'd5: v = -Q30HalfSqrt3;
      default: v = '0;
    endcase
    return v;
  endfunction

  // cos of k*60 degrees, Q30
  function automatic logic signed [31:0] cos_sixty(input logic [2:0] k);
    logic signed [31:0] v;
    case (k)
      3'd1, 3'd5: v = Q30Half;
      3'd2, 3'd4: v = -Q30Half;
      3'd3: v = -Q30One;
      default: v = Q30One;
    endcase
    return v;
  endfunction

endpackage

### design/svpwm_sine.sv
// pipelined quintic sine of a 16-bit angle, four register stages
module svpwm_sine import svpwm_pkg::*; #(
  parameter int DATA_BITS = 16
) (
  input  logic                        clk_i,
  input  logic [15:0]                 angle_i,
  output logic signed [DATA_BITS+1:0] sine_o
);

  logic [14:0] x;
  logic [14:0] x_q;
  logic [1:0]  sgn_q;
  logic [15:0] x2_q;
  logic [3:0]  sgn_q2;
  logic [30:0] t1_q;
  logic [15:0] x2_q3;
  logic [14:0] x_q3;
  logic [5:0]  sgn_q3;
  logic [30:0] t2_q;
  logic [14:0] x_q4;
  logic [30:0] s;
  logic [DATA_BITS:0] sf;
  logic        neg_q4;
  logic [45:0] p1;
  logic [46:0] p2;
  logic [45:0] p3;
  logic [30:0] t2_d;

  assign x = angle_i[14] ? 15'(15'd16384 - {1'b0, angle_i[13:0]}) : {1'b0, angle_i[13:0]};

  // stage 1: fold, square
  always_ff @(posedge clk_i) begin
    x_q  <= x;
    sgn_q <= {1'b0, angle_i[15]};
    x2_q <= 16'(({15'd0, x} * {15'd0, x}) >> 14);
  end

  assign p1 = 46'(SinC) * 46'(x2_q);

  // stage 2: b - c*x2
  always_ff @(posedge clk_i) begin
    t1_q   <= 31'(SinB - 31'(p1 >> 14));
    x2_q3  <= x2_q;
    x_q3   <= x_q;
    sgn_q2 <= {2'b0, sgn_q};
  end

  assign p2 = 47'(t1_q) * 47'(x2_q3);
  assign t2_d = 31'(SinA - 31'(p2 >> 14));

  // stage 3: a - t*x2
  always_ff @(posedge clk_i) begin
    t2_q   <= t2_d;
    x_q4   <= x_q3;
    sgn_q3 <= {2'b0, sgn_q2};
  end

  assign p3 = 46'(t2_q) * 46'(x_q4);
  assign s  = 31'(p3 >> 14);
  assign sf = (DATA_BITS + 1)'((s + (31'd1 << (29 - DATA_BITS))) >> (30 - DATA_BITS));

  // stage 4: multiply by x, round, sign
  always_ff @(posedge clk_i) begin
    neg_q4 <= sgn_q3[0];
    sine_o <= sgn_q3[0] ? -$signed({1'b0, sf}) : $signed({1'b0, sf});
  end

  logic unused;
  assign unused = ^{neg_q4, sgn_q3[5:1]};

endmodule

### design/svpwm_park.sv
// inverse park rotation and sector decision, three register stages
module svpwm_park import svpwm_pkg::*; #(
  parameter int DATA_BITS = 16
) (
  input  logic                      clk_i,
  input  logic signed [15:0]        d_i,
  input  logic signed [15:0]        q_i,
  input  logic signed [DATA_BITS+1:0] sin_i,
  input  logic signed [DATA_BITS+1:0] cos_i,
  output logic signed [DATA_BITS+1:0] alpha_o,
  output logic signed [DATA_BITS+1:0] beta_o,
  output logic [2:0]                sector_o
);

  localparam int PW = DATA_BITS + 17;

  logic signed [PW-1:0] dc_q, qs_q, ds_q, qc_q;
  logic signed [PW:0]   a_raw, b_raw;
  logic signed [DATA_BITS+1:0] a_d, b_d;
  logic signed [DATA_BITS+1:0] a_q, b_q;
  logic signed [2*DATA_BITS+5:0] bb, aa3;

  always_ff @(posedge clk_i) begin
    dc_q <= PW'(d_i) * PW'(cos_i);
    qs_q <= PW'(q_i) * PW'(sin_i);
    ds_q <= PW'(d_i) * PW'(sin_i);
    qc_q <= PW'(q_i) * PW'(cos_i);
  end

  assign a_raw = (PW+1)'(dc_q) - (PW+1)'(qs_q) + (PW+1)'(1 <<< 14);
  assign b_raw = (PW+1)'(ds_q) + (PW+1)'(qc_q) + (PW+1)'(1 <<< 14);
  assign a_d = (DATA_BITS+2)'(a_raw >>> 15);
  assign b_d = (DATA_BITS+2)'(b_raw >>> 15);

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign bb  = (2*DATA_BITS+6)'(b_q) * (2*DATA_BITS+6)'(b_q);
  assign aa3 = 3 * ((2*DATA_BITS+6)'(a_q) * (2*DATA_BITS+6)'(a_q));

  always_ff @(posedge clk_i) begin
    alpha_o  <= a_q;
    beta_o   <= b_q;
    sector_o <= sector_of_code({b_q > 0, bb > aa3, a_q > 0});
  end

endmodule

### design/svpwm_duty.sv
// active-vector times and phase duties, two register stages
module svpwm_duty import svpwm_pkg::*; #(
  parameter int DATA_BITS = 16
) (
  input  logic                        clk_i,
  input  logic signed [DATA_BITS+1:0] alpha_i,
  input  logic signed [DATA_BITS+1:0] beta_i,
  input  logic [2:0]                  sector_i,
  output logic [15:0]                 duty_u_o,
  output logic [15:0]                 duty_v_o,
  output logic [15:0]                 duty_w_o,
  output logic [2:0]                  sector_o
);

  localparam int TW = DATA_BITS + 36;
  localparam int SH = DATA_BITS + 15;

  logic signed [TW-1:0] am_q, bm_q, an_q, bn_q;
  logic signed [TW-1:0] tm, tn;
  logic [2:0] sec_q, pm, pn, prev, nxt;
  logic [15:0] duty [3];

  assign prev = sector_i - 3'd1;
  assign nxt  = (sector_i == 3'd6) ? 3'd1 : sector_i + 3'd1;

  always_ff @(posedge clk_i) begin
    am_q  <= TW'(alpha_i) * TW'(sin_sixty(sector_i));
    bm_q  <= TW'(beta_i) * TW'(cos_sixty(sector_i));
    an_q  <= TW'(alpha_i) * TW'(sin_sixty(prev));
    bn_q  <= TW'(beta_i) * TW'(cos_sixty(prev));
    sec_q <= sector_i;
    pm    <= switch_pattern(sector_i);
    pn    <= switch_pattern(nxt);
  end

  assign tm = am_q - bm_q;
  assign tn = bn_q - an_q;

  always_comb begin
    logic signed [TW+1:0] acc;
    logic signed [TW+1:0] r;
    for (int p = 0; p < 3; p++) begin
      acc = (TW+2)'(1) <<< (DATA_BITS + 30);
      acc = pm[2-p] ? acc + (TW+2)'(tm) : acc - (TW+2)'(tm);
      acc = pn[2-p] ? acc + (TW+2)'(tn) : acc - (TW+2)'(tn);
      r = (acc + ((TW+2)'(1) <<< (SH - 1))) >>> SH;
      if (r < 0) duty[p] = 16'd0;
      else if (r > 65535) duty[p] = 16'hFFFF;
      else duty[p] = 16'(r);
    end
  end

  always_ff @(posedge clk_i) begin
    duty_u_o <= duty[0];
    duty_v_o <= duty[1];
    duty_w_o <= duty[2];
    sector_o <= sec_q;
  end

endmodule

### design/svpwm_duty_from_dq.sv
// space vector pwm duties from rotor angle and d/q voltage commands
// usage: drive rotor_angle_i, volt_d_i, volt_q_i and pulse start_i for one
// cycle per word. busy_o is always low, so a new word may enter every cycle.
// results appear on duty_u_o, duty_v_o, duty_w_o and sector_number_o with
// done_o high for exactly one cycle, after the word has passed through
// four stages of sine/cosine polynomial, three of park rotation and sector
// test, one of active-vector products and one of time sums and duty rounding.
// throughput is one word per cycle, set by the fully pipelined multipliers.
// the receiver cannot hold results off; each word is shown for one cycle.
// reset clears only the valid chain; payload registers are not reset.
// words in flight at reset are dropped.
module svpwm_duty_from_dq import svpwm_pkg::*; #(
  parameter int DATA_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] rotor_angle_i,
  input  logic signed [15:0] volt_d_i,
  input  logic signed [15:0] volt_q_i,
  output logic        done_o,
  output logic [15:0] duty_u_o,
  output logic [15:0] duty_v_o,
  output logic [15:0] duty_w_o,
  output logic [2:0]  sector_number_o
);

  localparam int Lat = 9;

  logic signed [DATA_BITS+1:0] sin_w, cos_w;
  logic signed [15:0] d_q [4], q_q [4];
  logic signed [DATA_BITS+1:0] alpha, beta;
  logic [2:0] sector;
  logic [Lat-1:0] vld_q;

  assign busy_o = 1'b0;

  svpwm_sine #(.DATA_BITS(DATA_BITS)) u_sin (
    .clk_i, .angle_i(rotor_angle_i), .sine_o(sin_w));
  svpwm_sine #(.DATA_BITS(DATA_BITS)) u_cos (
    .clk_i, .angle_i(16'(rotor_angle_i + 16'd16384)), .sine_o(cos_w));

  // delay commands to match the sine pipeline
  always_ff @(posedge clk_i) begin
    d_q[0] <= volt_d_i;
    q_q[0] <= volt_q_i;
    for (int i = 1; i < 4; i++) begin
      d_q[i] <= d_q[i-1];
      q_q[i] <= q_q[i-1];
    end
  end

  svpwm_park #(.DATA_BITS(DATA_BITS)) u_park (
    .clk_i, .d_i(d_q[3]), .q_i(q_q[3]), .sin_i(sin_w), .cos_i(cos_w),
    .alpha_o(alpha), .beta_o(beta), .sector_o(sector));

  svpwm_duty #(.DATA_BITS(DATA_BITS)) u_duty (
    .clk_i, .alpha_i(alpha), .beta_i(beta), .sector_i(sector),
    .duty_u_o, .duty_v_o, .duty_w_o, .sector_o(sector_number_o));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start_i};
    end
  end

  assign done_o = vld_q[Lat-1];

endmodule
